### rtl/scancode_console_line_editor_assert.svh
// Assertion macros for the console line editor.
`ifndef SCANCODE_CONSOLE_LINE_EDITOR_ASSERT_SVH
`define SCANCODE_CONSOLE_LINE_EDITOR_ASSERT_SVH

`ifndef SYNTHESIS
`define SCLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scle check failed");
`define SCLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scle check failed");
`else
`define SCLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SCLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/scle_pkg.sv
// Types, scancodes and key map for the console line editor.
`default_nettype none

package scle_pkg;

	typedef enum logic [3:0] {
		WM_IDLE       = 4'd0,
		WM_UP         = 4'd1,
		WM_DOWN       = 4'd2,
		WM_LEFT       = 4'd3,
		WM_RIGHT      = 4'd4,
		WM_CAPS       = 4'd5,
		WM_SHIFT      = 4'd6,
		WM_CTRL       = 4'd7,
		WM_CTRL_SHIFT = 4'd8,
		WM_CTRL_ESC   = 4'd9,
		WM_CTRL_ALT   = 4'd10,
		WM_ALT        = 4'd11,
		WM_HOME       = 4'd12,
		WM_END        = 4'd13
	} wait_mode_t;

	localparam logic [7:0] SC_ESC      = 8'h01;
	localparam logic [7:0] SC_ENTER    = 8'h1C;
	localparam logic [7:0] SC_CTRL     = 8'h1D;
	localparam logic [7:0] SC_LSHIFT   = 8'h2A;
	localparam logic [7:0] SC_RSHIFT   = 8'h36;
	localparam logic [7:0] SC_ALT      = 8'h38;
	localparam logic [7:0] SC_CAPS     = 8'h3A;
	localparam logic [7:0] SC_F4       = 8'h3E;
	localparam logic [7:0] SC_HOME     = 8'h47;
	localparam logic [7:0] SC_UP       = 8'h48;
	localparam logic [7:0] SC_LEFT     = 8'h4B;
	localparam logic [7:0] SC_RIGHT    = 8'h4D;
	localparam logic [7:0] SC_END      = 8'h4F;
	localparam logic [7:0] SC_DOWN     = 8'h50;
	localparam logic [7:0] SC_LSHIFT_B = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_B = 8'hB6;
	localparam logic [7:0] SC_CAPS_B   = 8'hBA;
	localparam logic [7:0] SC_UP_B     = 8'hC8;
	localparam logic [7:0] SC_LEFT_B   = 8'hCB;
	localparam logic [7:0] SC_RIGHT_B  = 8'hCD;
	localparam logic [7:0] SC_DOWN_B   = 8'hD0;

	localparam logic [6:0] ASC_NUL   = 7'h00;
	localparam logic [6:0] ASC_BS    = 7'h08;
	localparam logic [6:0] ASC_LF    = 7'h0A;
	localparam logic [6:0] ASC_UP_A  = 7'h41;
	localparam logic [6:0] ASC_UP_Z  = 7'h5A;
	localparam logic [6:0] ASC_LO_A  = 7'h61;
	localparam logic [6:0] ASC_LO_Z  = 7'h7A;
	localparam logic [6:0] CASE_DIFF = 7'h20;

	localparam int KEY_MAP_LEN = 80;

	localparam logic [6:0] KEY_MAP [0:KEY_MAP_LEN-1] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00
	};

	function automatic logic [6:0] key_map(input logic [7:0] sc);
		logic [6:0] ch;
		ch = ASC_NUL;
		if (!sc[7] && (sc[6:0] < 7'(KEY_MAP_LEN))) begin
			ch = KEY_MAP[sc[6:0]];
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

### rtl/scancode_console_line_editor.sv
// Scancode line editor: cursor, modes and line-length memory with registered result beat.
// An accepted beat is held in stage 1, then on commit in the output register (out_valid).
// Sustained throughput is one beat per cycle while out_ready is high; line lengths are
// read from memory at accept time and forwarded past the write of the beat ahead.
// Reset clears cursor, modes, flags and the per-row valid bits of the line-length memory;
// no clearing pass, input is taken right after reset.
`default_nettype none

`include "scancode_console_line_editor_assert.svh"

module scancode_console_line_editor #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     kind,
	input  wire logic [7:0]               scan_byte,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          write_valid,
	output logic [$clog2(ROWS)-1:0]       write_row,
	output logic [$clog2(COLS)-1:0]       write_col,
	output logic [6:0]                    write_char,
	output logic [$clog2(ROWS)-1:0]       cursor_y,
	output logic [$clog2(COLS)-1:0]       cursor_x,
	output logic                          input_active,
	output logic                          close_request,
	output logic                          splash_request
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);
	localparam logic [RW-1:0] ROW_MAX = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_MAX = CW'(COLS - 1);

	// architectural state
	logic [RW-1:0]         row_q, row_d;
	logic [CW-1:0]         col_q, col_d;
	logic                  caps_q, caps_d;
	logic                  shift_q, shift_d;
	logic                  last_none_q, last_none_d;
	logic [6:0]            last_ch_q, last_ch_d;
	logic                  active_q, active_d;
	logic                  close_q, close_d;
	logic                  splash_q, splash_d;
	scle_pkg::wait_mode_t  mode_q, mode_d;

	// line-length memory
	logic [CW-1:0]         len_mem [ROWS];
	logic [ROWS-1:0]       len_vld_q;
	logic [RW-1:0]         raddr_a, raddr_b;
	logic                  mem_we, mem_wr;
	logic [CW-1:0]         mem_wd;

	// stage 1
	logic                  valid_s1;
	logic                  kind_s1;
	logic [7:0]            byte_s1;
	logic [CW-1:0]         rda_s1, rdb_s1, fwd_s1;
	logic                  vlda_s1, vldb_s1, hita_s1, hitb_s1;
	logic [CW-1:0]         len_a, len_b;

	// output register
	logic                  out_valid_q;
	logic                  wr_valid_q;
	logic [RW-1:0]         wr_row_q;
	logic [CW-1:0]         wr_col_q;
	logic [6:0]            wr_char_q;
	logic [RW-1:0]         cur_y_q;
	logic [CW-1:0]         cur_x_q;
	logic                  act_out_q, close_out_q, splash_out_q;

	// decode
	logic                  accept, commit;
	logic [6:0]            ch;
	logic                  is_shm, is_shb, last_hit;
	logic                  do_type;
	logic [6:0]            type_ch;
	logic                  wr_valid;
	logic [RW-1:0]         wr_row;
	logic [CW-1:0]         wr_col;
	logic [6:0]            wr_char;

	assign commit   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || commit;
	assign accept   = in_valid && in_ready;

	assign ch       = scle_pkg::key_map(byte_s1);
	assign is_shm   = (byte_s1 == scle_pkg::SC_LSHIFT) || (byte_s1 == scle_pkg::SC_RSHIFT);
	assign is_shb   = (byte_s1 == scle_pkg::SC_LSHIFT_B) || (byte_s1 == scle_pkg::SC_RSHIFT_B);
	assign last_hit = !last_none_q && (last_ch_q == ch);

	assign len_a = hita_s1 ? fwd_s1 : (vlda_s1 ? rda_s1 : '0);
	assign len_b = hitb_s1 ? fwd_s1 : (vldb_s1 ? rdb_s1 : '0);

	// read the row the next beat will see: the current beat's result if it retires now
	assign raddr_a = commit ? row_d : row_q;
	assign raddr_b = (raddr_a == '0) ? '0 : raddr_a - 1'b1;
	assign mem_wr  = commit && mem_we;

	// next wait mode
	always_comb begin
		mode_d = mode_q;
		if (!kind_s1 && active_q) begin
			unique case (mode_q)
				scle_pkg::WM_UP: begin
					if (byte_s1 == scle_pkg::SC_UP_B) mode_d = scle_pkg::WM_IDLE;
				end
				scle_pkg::WM_DOWN: begin
					if (byte_s1 == scle_pkg::SC_DOWN_B) mode_d = scle_pkg::WM_IDLE;
				end
				scle_pkg::WM_LEFT: begin
					if (byte_s1 == scle_pkg::SC_LEFT_B) mode_d = scle_pkg::WM_IDLE;
				end
				scle_pkg::WM_RIGHT: begin
					if (byte_s1 == scle_pkg::SC_RIGHT_B) mode_d = scle_pkg::WM_IDLE;
				end
				scle_pkg::WM_CAPS: begin
					if (byte_s1 == scle_pkg::SC_CAPS_B) mode_d = scle_pkg::WM_IDLE;
				end
				scle_pkg::WM_SHIFT: begin
					if (!is_shm) mode_d = scle_pkg::WM_IDLE;
				end
				scle_pkg::WM_CTRL: begin
					if (byte_s1 != scle_pkg::SC_CTRL) begin
						priority if (is_shm) mode_d = scle_pkg::WM_CTRL_SHIFT;
						else if (byte_s1 == scle_pkg::SC_ALT) mode_d = scle_pkg::WM_CTRL_ALT;
						else mode_d = scle_pkg::WM_IDLE;
					end
				end
				scle_pkg::WM_CTRL_SHIFT: begin
					if (!is_shm) begin
						mode_d = (byte_s1 == scle_pkg::SC_ESC) ? scle_pkg::WM_CTRL_ESC
						                                        : scle_pkg::WM_IDLE;
					end
				end
				scle_pkg::WM_CTRL_ESC: begin
					if (byte_s1 != scle_pkg::SC_ESC) mode_d = scle_pkg::WM_IDLE;
				end
				scle_pkg::WM_CTRL_ALT, scle_pkg::WM_ALT: begin
					if (byte_s1 != scle_pkg::SC_ALT) mode_d = scle_pkg::WM_IDLE;
				end
				scle_pkg::WM_HOME: begin
					if (byte_s1 != scle_pkg::SC_HOME) mode_d = scle_pkg::WM_IDLE;
				end
				scle_pkg::WM_END: begin
					if (byte_s1 != scle_pkg::SC_END) mode_d = scle_pkg::WM_IDLE;
				end
				default: begin
					mode_d = scle_pkg::WM_IDLE;
					if (!last_hit) begin
						priority if ((ch == scle_pkg::ASC_BS) || (ch == scle_pkg::ASC_LF)) begin
							mode_d = scle_pkg::WM_IDLE;
						end else if (byte_s1 == scle_pkg::SC_UP) begin
							if (row_q != '0) mode_d = scle_pkg::WM_UP;
						end else if (byte_s1 == scle_pkg::SC_DOWN) begin
							if (row_q != ROW_MAX) mode_d = scle_pkg::WM_DOWN;
						end else if (byte_s1 == scle_pkg::SC_LEFT) begin
							if (col_q != '0) mode_d = scle_pkg::WM_LEFT;
						end else if (byte_s1 == scle_pkg::SC_RIGHT) begin
							if (col_q < COL_MAX) mode_d = scle_pkg::WM_RIGHT;
						end else if (byte_s1 == scle_pkg::SC_CAPS) begin
							mode_d = scle_pkg::WM_CAPS;
						end else if (is_shm) begin
							mode_d = scle_pkg::WM_SHIFT;
						end else if (byte_s1 == scle_pkg::SC_CTRL) begin
							mode_d = scle_pkg::WM_CTRL;
						end else if (byte_s1 == scle_pkg::SC_ALT) begin
							mode_d = scle_pkg::WM_ALT;
						end else if (byte_s1 == scle_pkg::SC_HOME) begin
							mode_d = scle_pkg::WM_HOME;
						end else if (byte_s1 == scle_pkg::SC_END) begin
							mode_d = scle_pkg::WM_END;
						end else begin
							mode_d = scle_pkg::WM_IDLE;
						end
					end
				end
			endcase
		end
	end

	// cursor, flags, cell write and line-length update
	always_comb begin
		row_d       = row_q;
		col_d       = col_q;
		caps_d      = caps_q;
		shift_d     = shift_q;
		last_none_d = last_none_q;
		last_ch_d   = last_ch_q;
		active_d    = active_q;
		close_d     = close_q;
		splash_d    = splash_q;
		mem_we      = 1'b0;
		mem_wd      = len_a;
		do_type     = 1'b0;
		type_ch     = ch;
		wr_valid    = 1'b0;
		wr_row      = '0;
		wr_col      = '0;
		wr_char     = scle_pkg::ASC_NUL;

		if (kind_s1) begin
			active_d = 1'b1;
		end else if (!active_q) begin
			col_d = '0;
		end else begin
			splash_d = 1'b0;
			unique case (mode_q)
				scle_pkg::WM_UP, scle_pkg::WM_DOWN, scle_pkg::WM_LEFT, scle_pkg::WM_RIGHT,
				scle_pkg::WM_CTRL_SHIFT, scle_pkg::WM_CTRL_ESC, scle_pkg::WM_CTRL_ALT,
				scle_pkg::WM_HOME, scle_pkg::WM_END: begin
					row_d = row_q;
				end
				scle_pkg::WM_CAPS: begin
					if (byte_s1 == scle_pkg::SC_CAPS_B) caps_d = !caps_q;
				end
				scle_pkg::WM_SHIFT: begin
					if (!is_shm && !is_shb) begin
						shift_d = 1'b1;
						do_type = (ch != scle_pkg::ASC_NUL) && (ch != scle_pkg::ASC_BS)
						          && (ch != scle_pkg::ASC_LF);
					end
				end
				scle_pkg::WM_CTRL: begin
					priority if (byte_s1 == scle_pkg::SC_HOME) begin
						row_d = '0;
						col_d = '0;
					end else if (byte_s1 == scle_pkg::SC_ENTER) begin
						row_d    = '0;
						col_d    = '0;
						splash_d = 1'b1;
						active_d = 1'b0;
						caps_d   = 1'b0;
						shift_d  = 1'b0;
					end else if (byte_s1 == scle_pkg::SC_END) begin
						row_d = ROW_MAX;
						col_d = COL_MAX;
					end else begin
						row_d = row_q;
					end
				end
				scle_pkg::WM_ALT: begin
					if (byte_s1 == scle_pkg::SC_F4) close_d = 1'b1;
				end
				default: begin
					if (last_hit) begin
						last_none_d = 1'b1;
					end else begin
						last_none_d = 1'b0;
						last_ch_d   = ch;
						priority if (ch == scle_pkg::ASC_BS) begin
							if (col_q != '0) begin
								col_d = col_q - 1'b1;
								if (len_a != '0) begin
									mem_we = 1'b1;
									mem_wd = len_a - 1'b1;
								end
							end else if (row_q != '0) begin
								row_d = row_q - 1'b1;
								col_d = len_b;
							end
							wr_valid = 1'b1;
							wr_row   = row_d;
							wr_col   = col_d;
							wr_char  = scle_pkg::ASC_NUL;
						end else if (ch == scle_pkg::ASC_LF) begin
							col_d    = '0;
							if (row_q != ROW_MAX) row_d = row_q + 1'b1;
							active_d = 1'b0;
							caps_d   = 1'b0;
							shift_d  = 1'b0;
						end else if (byte_s1 == scle_pkg::SC_UP) begin
							if (row_q != '0) row_d = row_q - 1'b1;
						end else if (byte_s1 == scle_pkg::SC_DOWN) begin
							if (row_q != ROW_MAX) row_d = row_q + 1'b1;
						end else if (byte_s1 == scle_pkg::SC_LEFT) begin
							if (col_q != '0) col_d = col_q - 1'b1;
						end else if (byte_s1 == scle_pkg::SC_RIGHT) begin
							if (col_q < COL_MAX) col_d = col_q + 1'b1;
						end else if (is_shb) begin
							shift_d = 1'b0;
						end else if (byte_s1 == scle_pkg::SC_HOME) begin
							col_d = '0;
						end else if (byte_s1 == scle_pkg::SC_END) begin
							col_d = COL_MAX;
						end else if ((byte_s1 == scle_pkg::SC_CAPS) || is_shm
						             || (byte_s1 == scle_pkg::SC_CTRL)
						             || (byte_s1 == scle_pkg::SC_ALT)) begin
							row_d = row_q;
						end else begin
							do_type = (ch != scle_pkg::ASC_NUL);
						end
					end
				end
			endcase

			if (do_type) begin
				if (caps_d != shift_d) begin
					if ((ch >= scle_pkg::ASC_LO_A) && (ch <= scle_pkg::ASC_LO_Z)) begin
						type_ch = ch - scle_pkg::CASE_DIFF;
					end
				end else if (caps_d && shift_d) begin
					if ((ch >= scle_pkg::ASC_UP_A) && (ch <= scle_pkg::ASC_UP_Z)) begin
						type_ch = ch + scle_pkg::CASE_DIFF;
					end
				end
				wr_valid = 1'b1;
				wr_row   = row_q;
				wr_col   = col_q;
				wr_char  = type_ch;
				if (col_q >= COL_MAX) begin
					if (row_q != ROW_MAX) row_d = row_q + 1'b1;
					col_d = '0;
				end else begin
					col_d = col_q + 1'b1;
					if (len_a != COL_MAX) begin
						mem_we = 1'b1;
						mem_wd = len_a + 1'b1;
					end
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			caps_q      <= 1'b0;
			shift_q     <= 1'b0;
			last_none_q <= 1'b1;
			last_ch_q   <= '0;
			active_q    <= 1'b0;
			close_q     <= 1'b0;
			splash_q    <= 1'b0;
			mode_q      <= scle_pkg::WM_IDLE;
			len_vld_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				row_q       <= row_d;
				col_q       <= col_d;
				caps_q      <= caps_d;
				shift_q     <= shift_d;
				last_none_q <= last_none_d;
				last_ch_q   <= last_ch_d;
				active_q    <= active_d;
				close_q     <= close_d;
				splash_q    <= splash_d;
				mode_q      <= mode_d;
			end
			if (mem_wr) len_vld_q[row_q] <= 1'b1;
			if (accept) valid_s1 <= 1'b1;
			else if (commit) valid_s1 <= 1'b0;
			if (commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// memory, stage 1 payload, forwarding
	always_ff @(posedge clk) begin
		if (mem_wr) len_mem[row_q] <= mem_wd;
		if (accept) begin
			kind_s1 <= kind;
			byte_s1 <= scan_byte;
			rda_s1  <= len_mem[raddr_a];
			rdb_s1  <= len_mem[raddr_b];
			vlda_s1 <= len_vld_q[raddr_a];
			vldb_s1 <= len_vld_q[raddr_b];
			hita_s1 <= mem_wr && (row_q == raddr_a);
			hitb_s1 <= mem_wr && (row_q == raddr_b);
			fwd_s1  <= mem_wd;
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (commit) begin
			wr_valid_q   <= wr_valid;
			wr_row_q     <= wr_row;
			wr_col_q     <= wr_col;
			wr_char_q    <= wr_char;
			cur_y_q      <= row_d;
			cur_x_q      <= col_d;
			act_out_q    <= active_d;
			close_out_q  <= close_d;
			splash_out_q <= splash_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign write_valid    = wr_valid_q;
	assign write_row      = wr_row_q;
	assign write_col      = wr_col_q;
	assign write_char     = wr_char_q;
	assign cursor_y       = cur_y_q;
	assign cursor_x       = cur_x_q;
	assign input_active   = act_out_q;
	assign close_request  = close_out_q;
	assign splash_request = splash_out_q;

	`SCLE_ASSERT_IMP(a_row_range, clk, arst_n, 1'b1, row_q <= ROW_MAX)
	`SCLE_ASSERT_IMP(a_col_range, clk, arst_n, 1'b1, col_q <= COL_MAX)
	`SCLE_ASSERT_IMP(a_idle_mods, clk, arst_n, !active_q, !caps_q && !shift_q)
	`SCLE_ASSERT_IMP(a_idle_mode, clk, arst_n, !active_q, mode_q == scle_pkg::WM_IDLE)
	`SCLE_ASSERT_NXT(a_commit_out, clk, arst_n, commit, out_valid_q)

endmodule

`default_nettype wire
